>>> rtl/core/swcd_pkg.sv
`timescale 1ns / 1ps

package swcd_pkg;

   // Number of payload bytes collected after an enabled header (1 to 4)
   localparam int PAYLOAD_BYTES = 4;
   localparam int PAYLOAD_SHIFT = 8 * (4 - PAYLOAD_BYTES);

   // Register reset values
   localparam logic [26:0] SYNC_PATTERN_RESET   = 27'h091A2B0;
   localparam logic [15:0] TIMEOUT_TICKS_RESET  = 16'd100;
   localparam logic [31:0] ENABLE_MASK_RESET    = 32'h80725400;

   localparam logic [15:0] TICKS_MAX = 16'hFFFF;

   // Input opcodes
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result event kinds
   localparam logic [1:0] EV_COMMAND = 2'd0;
   localparam logic [1:0] EV_UNUSED  = 2'd1;
   localparam logic [1:0] EV_TIMEOUT = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_SYNC_PATTERN = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT      = 2'd1;
   localparam logic [1:0] CSR_ENABLE_MASK  = 2'd2;

   typedef struct packed {
      logic       opcode;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [4:0]  command_code;
      logic [31:0] payload;
   } rsp_type;

   typedef struct packed {
      logic [26:0] sync_pattern;
      logic [15:0] timeout_ticks;
      logic [31:0] command_enable_mask;
   } cfg_type;

   // One classified item between front and back
   typedef struct packed {
      logic        is_tick;
      logic        header_hit;
      logic [31:0] window;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

>>> rtl/core/swcd_front.sv
`timescale 1ns / 1ps

module swcd_front
   import swcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_type      req_item,
   input  q_status_type q_status,
   input  cfg_type      cfg,
   output logic         req_stall,
   output logic         push,
   output entry_type    push_entry
);

   logic [31:0] window_ff;
   logic [31:0] window_in;
   logic        is_tick;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;
   assign is_tick   = (req_item.opcode == OP_TICK);

   // Newest byte enters at the top, oldest leaves at the bottom
   always_comb begin
      window_in = window_ff;
      if (push && !is_tick) begin
         window_in = {req_item.byte_value, window_ff[31:8]};
      end
   end

   // Classify: header test is on the window after this byte
   always_comb begin
      push_entry.is_tick    = is_tick;
      push_entry.window     = window_in;
      push_entry.header_hit = !is_tick && (window_in[31:5] == cfg.sync_pattern);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

endmodule

>>> rtl/core/swcd_queue.sv
`timescale 1ns / 1ps

module swcd_queue
   import swcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output entry_type    head_entry,
   output q_status_type q_status
);

   entry_type   entries_ff [2];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;

   assign head_entry     = entries_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == 2'd0);
   assign q_status.full  = (count_ff == 2'd2);

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/core/swcd_back.sv
`timescale 1ns / 1ps

module swcd_back
   import swcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  entry_type    head_entry,
   input  q_status_type q_status,
   input  cfg_type      cfg,
   input  logic         rsp_stall,
   output logic         pop,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   logic        hunting_ff;
   logic        hunting_in;
   logic [4:0]  code_ff;
   logic [4:0]  code_in;
   logic [2:0]  bytes_ff;
   logic [2:0]  bytes_in;
   logic [15:0] elapsed_ff;
   logic [15:0] elapsed_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_item_ff;
   rsp_type     rsp_item_in;

   logic        out_free;
   logic        emit;
   rsp_type     result;
   logic [15:0] elapsed_inc;
   logic [2:0]  bytes_inc;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign pop         = !q_status.empty && out_free;
   assign elapsed_inc = (elapsed_ff < TICKS_MAX) ? elapsed_ff + 16'd1 : elapsed_ff;
   assign bytes_inc   = bytes_ff + 3'd1;

   // Execute one item
   always_comb begin
      hunting_in          = hunting_ff;
      code_in             = code_ff;
      bytes_in            = bytes_ff;
      elapsed_in          = elapsed_ff;
      emit                = 1'b0;
      result.event_kind   = EV_COMMAND;
      result.command_code = code_ff;
      result.payload      = '0;
      if (pop) begin
         if (head_entry.is_tick) begin
            elapsed_in = elapsed_inc;
            if (!hunting_ff && (elapsed_inc >= cfg.timeout_ticks)) begin
               hunting_in        = 1'b1;
               emit              = 1'b1;
               result.event_kind = EV_TIMEOUT;
            end
         end else if (hunting_ff) begin
            if (head_entry.header_hit) begin
               hunting_in = 1'b0;
               code_in    = head_entry.window[4:0];
               bytes_in   = 3'd0;
               elapsed_in = 16'd0;
            end
         end else if (!cfg.command_enable_mask[code_ff]) begin
            // Disabled code: report it, then the same byte may open a new header
            emit              = 1'b1;
            result.event_kind = EV_UNUSED;
            hunting_in        = !head_entry.header_hit;
            if (head_entry.header_hit) begin
               code_in    = head_entry.window[4:0];
               bytes_in   = 3'd0;
               elapsed_in = 16'd0;
            end
         end else begin
            bytes_in = bytes_inc;
            if (bytes_inc >= 3'(PAYLOAD_BYTES)) begin
               hunting_in        = 1'b1;
               emit              = 1'b1;
               result.event_kind = EV_COMMAND;
               result.payload    = head_entry.window >> PAYLOAD_SHIFT;
            end
         end
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         rsp_item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunting_ff   <= 1'b1;
         code_ff      <= 5'd0;
         bytes_ff     <= 3'd0;
         elapsed_ff   <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hunting_ff   <= hunting_in;
         code_ff      <= code_in;
         bytes_ff     <= bytes_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> rtl/core/sync_word_command_deframer_core.sv
`timescale 1ns / 1ps

// Sync-word command deframer. Each input item is a received byte or a one
// millisecond tick; results are command, unused-command and timeout events.
// One item is accepted every cycle unless the queue is full (req_stall):
// the front shifts the byte window and tests the header in the accepting
// cycle, a two-entry queue hands the item to the back, which updates hunt
// state, byte count and tick counter and writes any event into the output
// register. Registers are written through the csr_ port, which is always
// ready; the user must write them only while the block is idle (not enforced).

module sync_word_command_deframer_core
   import swcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  req_type     req_item,
   output logic        req_stall,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        rsp_stall,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   logic         push;
   entry_type    push_entry;
   logic         pop;
   entry_type    head_entry;
   q_status_type q_status;

   assign csr_ready = 1'b1;

   // Register writes; unknown index is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SYNC_PATTERN: cfg_in.sync_pattern        = csr_data[26:0];
            CSR_TIMEOUT:      cfg_in.timeout_ticks       = csr_data[15:0];
            CSR_ENABLE_MASK:  cfg_in.command_enable_mask = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_pattern        <= SYNC_PATTERN_RESET;
         cfg_ff.timeout_ticks       <= TIMEOUT_TICKS_RESET;
         cfg_ff.command_enable_mask <= ENABLE_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .q_status   (q_status),
      .cfg        (cfg_ff),
      .req_stall  (req_stall),
      .push       (push),
      .push_entry (push_entry)
   );

   swcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   swcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .cfg        (cfg_ff),
      .rsp_stall  (rsp_stall),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   // Checks
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.empty && q_status.full))
      else $error("queue both empty and full");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !q_status.empty)
      else $error("accepted item not held in queue");

   a_event_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.event_kind == EV_COMMAND ||
                     rsp_item.event_kind == EV_UNUSED ||
                     rsp_item.event_kind == EV_TIMEOUT))
      else $error("bad event kind");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.event_kind != EV_COMMAND) |-> (rsp_item.payload == 32'd0))
      else $error("payload set on non-command event");

endmodule
